>>> rtl/core/optical_flow_frame_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the optical flow frame parser core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_FLOW_FRAME_PARSER_CORE_MACROS_SVH
`define OPTICAL_FLOW_FRAME_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define OFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

>>> rtl/core/ofp_pkg.sv
// ----------------------------------------------------------------------------
// ofp_pkg
// Constants, codes and shared types of the optical flow frame parser.
// ----------------------------------------------------------------------------
package ofp_pkg;

  localparam int PAYLOAD_BYTES = 10;
  localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SNAP = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_SNAP   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_HEAD = 1'b0;
  localparam logic CFG_TAIL = 1'b1;

  // End of a frame as seen by the parser.
  typedef struct packed {
    logic               done;
    logic               good;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic        [15:0] integ;
    logic        [15:0] height;
    logic        [7:0]  quality;
  } frame_t;

  // Accumulator contents offered to a snapshot.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic        [15:0] count;
    logic        [31:0] integ;
    logic        [31:0] total;
    logic        [7:0]  quality;
  } snap_t;

endpackage

>>> rtl/core/ofp_parser.sv
// ----------------------------------------------------------------------------
// ofp_parser
// Framing machine: head, length, payload with running XOR, checksum, tail.
// ----------------------------------------------------------------------------
module ofp_parser import ofp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] head_byte,
  input  logic [7:0] tail_byte,
  output frame_t     frame
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAY  = 3'd2,
    PH_CSUM = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [5:0] payload_index;
  logic [5:0] payload_index_next;
  logic [7:0] xor_running;
  logic [7:0] xor_received;
  logic [7:0] payload_store [PAYLOAD_BYTES];

  assign payload_index_next = payload_index + 6'd1;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: if (rx_byte == head_byte) phase_next = PH_LEN;
      PH_LEN: begin
        if (rx_byte == 8'(PAYLOAD_BYTES)) phase_next = PH_PAY;
        else phase_next = PH_IDLE;
      end
      PH_PAY: if (payload_index_next >= 6'(PAYLOAD_BYTES)) phase_next = PH_CSUM;
      PH_CSUM: phase_next = PH_TAIL;
      PH_TAIL: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      payload_index <= 6'd0;
      xor_running   <= 8'd0;
      xor_received  <= 8'd0;
    end else if (step) begin
      phase <= phase_next;
      case (phase)
        PH_LEN: begin
          if (rx_byte == 8'(PAYLOAD_BYTES)) begin
            payload_index <= 6'd0;
            xor_running   <= 8'd0;
          end
        end
        PH_PAY: begin
          xor_running   <= xor_running ^ rx_byte;
          payload_index <= payload_index_next;
        end
        PH_CSUM: xor_received <= rx_byte;
        default: ;
      endcase
    end
  end

  // Payload bytes hold no reset; decoding only follows a full payload.
  always_ff @(posedge clk) begin
    if (step && phase == PH_PAY && payload_index < 6'(PAYLOAD_BYTES)) begin
      payload_store[payload_index[PAYLOAD_IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    frame.done    = step && phase == PH_TAIL;
    frame.good    = rx_byte == tail_byte && xor_received == xor_running;
    frame.raw_x   = {payload_store[1], payload_store[0]};
    frame.raw_y   = {payload_store[3], payload_store[2]};
    frame.integ   = {payload_store[5], payload_store[4]};
    frame.height  = {payload_store[7], payload_store[6]};
    frame.quality = payload_store[8];
  end

endmodule

>>> rtl/core/ofp_accum.sv
// ----------------------------------------------------------------------------
// ofp_accum
// Flow, count and time sums of accepted frames, read and cleared by snapshot.
// ----------------------------------------------------------------------------
module ofp_accum import ofp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   snap_req,
  input  frame_t frame,
  output snap_t  snap
);

  logic               last_valid;
  logic [7:0]         last_quality;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic [15:0]        acc_count;
  logic [31:0]        acc_integration;
  logic [31:0]        frames_accepted;
  logic               add;

  assign add = frame.done && frame.good;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid      <= 1'b0;
      last_quality    <= 8'd0;
      acc_x           <= 32'sd0;
      acc_y           <= 32'sd0;
      acc_count       <= 16'd0;
      acc_integration <= 32'd0;
      frames_accepted <= 32'd0;
    end else if (snap_req) begin
      acc_x           <= 32'sd0;
      acc_y           <= 32'sd0;
      acc_count       <= 16'd0;
      acc_integration <= 32'd0;
    end else if (add) begin
      last_quality    <= frame.quality;
      last_valid      <= frame.quality != 8'd0;
      acc_x           <= acc_x + 32'(frame.raw_x);
      acc_y           <= acc_y + 32'(frame.raw_y);
      acc_count       <= acc_count + 16'd1;
      acc_integration <= acc_integration + {16'd0, frame.integ};
      frames_accepted <= frames_accepted + 32'd1;
    end
  end

  always_comb begin
    snap.valid   = acc_count != 16'd0 && last_valid;
    snap.sum_x   = acc_x;
    snap.sum_y   = acc_y;
    snap.count   = acc_count;
    snap.integ   = acc_integration;
    snap.total   = frames_accepted;
    snap.quality = last_quality;
  end

endmodule

>>> rtl/core/optical_flow_frame_parser_core.sv
// ----------------------------------------------------------------------------
// optical_flow_frame_parser_core
// Sensor frame parser with flow accumulation and read-and-clear snapshot.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries either a received byte
// (operation = byte) or a snapshot request. Bytes run the framing machine;
// the tail byte of a frame yields an accept or reject transaction, and a
// snapshot yields the sums as they stood, then clears them. Other bytes
// yield nothing.
// Output channel (out_valid/out_ready) presents one result from a single
// output register. A result appears in the cycle after its input transaction.
// Throughput is one input transaction per cycle: the parser state and sums
// update in the accepting cycle, so the next byte may follow at once.
// When the receiver stalls with a result waiting, in_ready drops until that
// result is taken; in_ready is high whenever the output register is empty
// or being read in the same cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the head and tail
// byte values, which are held in registers.
// Reset clears the framing machine, sums, counters, head and tail values
// and the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "optical_flow_frame_parser_core_macros.svh"

module optical_flow_frame_parser_core import ofp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic signed [15:0] raw_x,
  output logic signed [15:0] raw_y,
  output logic [15:0]        integration_time,
  output logic [15:0]        height,
  output logic [7:0]         quality,
  output logic               valid_res,
  output logic signed [31:0] sum_x,
  output logic signed [31:0] sum_y,
  output logic [15:0]        sum_count,
  output logic [31:0]        sum_integration,
  output logic [31:0]        frame_total
);

  logic [7:0] head_byte;
  logic [7:0] tail_byte;
  logic       accept;
  logic       byte_step;
  logic       snap_req;
  logic       has_result;
  frame_t     frame;
  snap_t      snap;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign byte_step = accept && operation == OP_BYTE;
  assign snap_req  = accept && operation == OP_SNAP;
  assign has_result = snap_req || frame.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= 8'd0;
      tail_byte <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD: head_byte <= cfg_data;
        CFG_TAIL: tail_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  ofp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (byte_step),
    .rx_byte   (rx_byte),
    .head_byte (head_byte),
    .tail_byte (tail_byte),
    .frame     (frame)
  );

  ofp_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .snap_req (snap_req),
    .frame    (frame),
    .snap     (snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; loaded only together with a new result.
  always_ff @(posedge clk) begin
    if (has_result) begin
      raw_x            <= 16'sd0;
      raw_y            <= 16'sd0;
      integration_time <= 16'd0;
      height           <= 16'd0;
      quality          <= snap.quality;
      valid_res        <= 1'b0;
      sum_x            <= 32'sd0;
      sum_y            <= 32'sd0;
      sum_count        <= 16'd0;
      sum_integration  <= 32'd0;
      frame_total      <= 32'd0;
      if (snap_req) begin
        result_kind     <= KIND_SNAP;
        valid_res       <= snap.valid;
        sum_x           <= snap.sum_x;
        sum_y           <= snap.sum_y;
        sum_count       <= snap.count;
        sum_integration <= snap.integ;
        frame_total     <= snap.total;
      end else if (frame.good) begin
        result_kind      <= KIND_ACCEPT;
        raw_x            <= frame.raw_x;
        raw_y            <= frame.raw_y;
        integration_time <= frame.integ;
        height           <= frame.height;
        quality          <= frame.quality;
      end else begin
        result_kind <= KIND_REJECT;
      end
    end
  end

  `OFP_ASSERT_NEXT(a_snap_result, snap_req, out_valid && result_kind == KIND_SNAP)
  `OFP_ASSERT_IMPL(a_no_overwrite, out_valid && !out_ready, !in_ready && !has_result)
  `OFP_ASSERT_IMPL(a_frame_sums_zero, out_valid && result_kind != KIND_SNAP,
                   sum_count == 16'd0 && valid_res == 1'b0 && frame_total == 32'd0)

endmodule
